// ===== rtl/rpr_pkg.sv =====
// Shared constants and controller/datapath interface types for the resampler.
`default_nettype none
package rpr_pkg;

  localparam int MAX_PHASES   = 16;
  localparam int MAX_TAPS     = 32;
  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_WIDTH   = 16;
  localparam int ACC_WIDTH    = 40;
  localparam int MAX_OUT      = 16;

  localparam int PHASE_W   = $clog2(MAX_PHASES);
  localparam int TAP_W     = $clog2(MAX_TAPS);
  localparam int SLOTS     = MAX_PHASES * MAX_TAPS;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int PROD_W    = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int COUNT_W   = $clog2(MAX_OUT + 1);
  localparam int FRAC_BITS = COEF_WIDTH - 1;

  // Configuration register field widths
  localparam int INTERP_W = 5;
  localparam int DECIM_W  = 5;
  localparam int TAPS_W   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_INTERP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECIM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS   = 2'd2;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_COEF   = 1'b1;

  typedef struct packed {
    logic              shift;
    logic              coef_we;
    logic              mac_issue;
    logic              acc_clear;
    logic              load_out;
    logic              out_last;
    logic [SLOT_W-1:0] coef_addr;
    logic [TAP_W-1:0]  hist_idx;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/rational_polyphase_resampler.sv =====
// Top level of the rational polyphase resampler: controller, datapath and checks.
// A coefficient word is written into the coefficient RAM as it is taken. A sample word
// causes K outputs (0..16), each computed over the T taps of its phase by the single
// shared multiply-accumulate, which walks one tap per cycle; no new word is taken until
// all K outputs are loaded. Reset clears the sample history, residue and
// phase, sets L=1, D=1, T=32 and leaves the coefficient RAM unwritten.
`default_nettype none
module rational_polyphase_resampler (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    func,
  input  logic signed [rpr_pkg::SAMPLE_WIDTH-1:0] sample_in,
  input  logic [rpr_pkg::SLOT_W-1:0]              coef_index,
  input  logic signed [rpr_pkg::COEF_WIDTH-1:0]   coef_value,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [rpr_pkg::SAMPLE_WIDTH-1:0] sample_out,
  output logic                                    last,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [rpr_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [rpr_pkg::CFG_DATA_W-1:0]          cfg_data
);
  import rpr_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  rpr_controller u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .status   (status)
  );

  rpr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .sample_in (sample_in),
    .coef_index(coef_index),
    .coef_value(coef_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample_out(sample_out),
    .last      (last)
  );

  // An output word is only loaded when the output register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> status.out_free)
    else $error("output loaded over an untaken word");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded output word not presented");

  // No new word is taken while the multiply-accumulate is walking taps.
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.mac_issue |-> !in_ready && !cmd.shift && !cmd.coef_we)
    else $error("input taken during accumulation");

endmodule
`default_nettype wire

// ===== rtl/rpr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rpr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/rpr_datapath.sv =====
// Datapath: sample history, coefficient RAM, multiply-accumulate pipeline and output word.
`default_nettype none
module rpr_datapath (
  input  logic                                    clk,
  input  logic                                    rst,
  input  rpr_pkg::ctl_cmd_t                       cmd,
  output rpr_pkg::dp_status_t                     status,
  input  logic signed [rpr_pkg::SAMPLE_WIDTH-1:0] sample_in,
  input  logic [rpr_pkg::SLOT_W-1:0]              coef_index,
  input  logic signed [rpr_pkg::COEF_WIDTH-1:0]   coef_value,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [rpr_pkg::SAMPLE_WIDTH-1:0] sample_out,
  output logic                                    last
);
  import rpr_pkg::*;

  localparam logic signed [ACC_WIDTH-1:0] ROUND_HALF = ACC_WIDTH'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [SAMPLE_WIDTH-1:0] hist [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] hist_q;
  logic [COEF_WIDTH-1:0]          coef_rd;
  logic                           v1, v2;
  logic signed [PROD_W-1:0]       prod;
  logic signed [ACC_WIDTH-1:0]    acc;
  logic signed [ACC_WIDTH-1:0]    rounded;
  logic signed [ACC_WIDTH-1:0]    shifted;
  logic signed [SAMPLE_WIDTH-1:0] sat;
  logic                           fits;

  rpr_ram #(
    .WIDTH(COEF_WIDTH),
    .DEPTH(SLOTS)
  ) u_coef_ram (
    .clk  (clk),
    .we   (cmd.coef_we),
    .waddr(coef_index),
    .wdata(coef_value),
    .raddr(cmd.coef_addr),
    .rdata(coef_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        hist[i] <= '0;
      end
    end else if (cmd.shift) begin
      hist[0] <= sample_in;
      for (int i = 1; i < MAX_TAPS; i++) begin
        hist[i] <= hist[i-1];
      end
    end
  end

  // Three-stage MAC: operand fetch, product, accumulate.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.mac_issue;
      v2 <= v1;
    end
    hist_q <= hist[cmd.hist_idx];
    prod   <= $signed(coef_rd) * hist_q;
    if (cmd.acc_clear) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_WIDTH'(prod);
    end
  end

  always_comb begin
    rounded = acc + ROUND_HALF;
    shifted = rounded >>> FRAC_BITS;
    fits    = (&shifted[ACC_WIDTH-1:SAMPLE_WIDTH-1]) | ~(|shifted[ACC_WIDTH-1:SAMPLE_WIDTH-1]);
    if (fits) begin
      sat = shifted[SAMPLE_WIDTH-1:0];
    end else if (shifted[ACC_WIDTH-1]) begin
      sat = SAT_MIN;
    end else begin
      sat = SAT_MAX;
    end
  end

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.load_out) begin
      sample_out <= sat;
      last       <= cmd.out_last;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rpr_controller.sv =====
// Controller: configuration registers, output scheduling and tap sequencing.
`default_nettype none
module rpr_controller (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             func,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rpr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rpr_pkg::CFG_DATA_W-1:0]   cfg_data,
  output rpr_pkg::ctl_cmd_t                cmd,
  input  rpr_pkg::dp_status_t              status
);
  import rpr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ISSUE,
    S_DRAIN1,
    S_DRAIN2,
    S_FINISH
  } state_t;

  localparam logic [INTERP_W-1:0] L_MAX = INTERP_W'(MAX_PHASES);
  localparam logic [DECIM_W-1:0]  D_MAX = DECIM_W'(MAX_PHASES);
  localparam logic [TAPS_W-1:0]   T_MAX = TAPS_W'(MAX_TAPS);
  localparam logic [COUNT_W-1:0]  OUT_LIMIT = COUNT_W'(MAX_OUT);

  state_t               state;
  logic [INTERP_W-1:0]  up_factor;
  logic [DECIM_W-1:0]   down_factor;
  logic [TAPS_W-1:0]    taps_per_phase;
  logic [5:0]           residue;
  logic [PHASE_W-1:0]   phase;
  logic [COUNT_W-1:0]   count;
  logic [TAP_W-1:0]     tap;

  logic [INTERP_W-1:0]  l_eff;
  logic [DECIM_W-1:0]   d_eff;
  logic [TAPS_W-1:0]    t_eff;
  logic [5:0]           l_ext;
  logic [5:0]           residue_next;
  logic [PHASE_W:0]     phase_inc;
  logic [TAPS_W-1:0]    hist_pos;
  logic                 in_acc;
  logic                 due;
  logic                 last_flag;

  always_comb begin
    l_eff = (up_factor == '0) ? INTERP_W'(1) :
            (up_factor > L_MAX) ? L_MAX : up_factor;
    d_eff = (down_factor == '0) ? DECIM_W'(1) :
            (down_factor > D_MAX) ? D_MAX : down_factor;
    t_eff = (taps_per_phase == '0) ? TAPS_W'(1) :
            (taps_per_phase > T_MAX) ? T_MAX : taps_per_phase;
    l_ext        = 6'(l_eff);
    residue_next = residue + 6'(d_eff);
    phase_inc    = {1'b0, phase} + (PHASE_W+1)'(1);
    hist_pos     = t_eff - TAPS_W'(1) - TAPS_W'(tap);
    due          = (residue < l_ext) && (count != OUT_LIMIT);
    last_flag    = (residue_next >= l_ext) || (count == OUT_LIMIT - COUNT_W'(1));
  end

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;

  always_comb begin
    cmd.shift     = in_acc && (func == FUNC_SAMPLE);
    cmd.coef_we   = in_acc && (func == FUNC_COEF);
    cmd.mac_issue = (state == S_ISSUE);
    cmd.acc_clear = (state == S_CHECK);
    cmd.load_out  = (state == S_FINISH) && status.out_free;
    cmd.out_last  = last_flag;
    cmd.coef_addr = {phase, tap};
    cmd.hist_idx  = hist_pos[TAP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      up_factor      <= INTERP_W'(1);
      down_factor    <= DECIM_W'(1);
      taps_per_phase <= T_MAX;
      residue        <= '0;
      phase          <= '0;
      count          <= '0;
      tap            <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_INTERP: up_factor      <= cfg_data[INTERP_W-1:0];
          REG_DECIM:  down_factor    <= cfg_data[DECIM_W-1:0];
          REG_TAPS:   taps_per_phase <= cfg_data[TAPS_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && (func == FUNC_SAMPLE)) begin
            // A phase left over from a larger interpolation factor restarts at zero.
            if ({1'b0, phase} >= l_eff) begin
              phase <= '0;
            end
            count <= '0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (due) begin
            tap   <= '0;
            state <= S_ISSUE;
          end else begin
            residue <= (residue >= l_ext) ? residue - l_ext : '0;
            state   <= S_IDLE;
          end
        end
        S_ISSUE: begin
          if (TAPS_W'(tap) == t_eff - TAPS_W'(1)) begin
            state <= S_DRAIN1;
          end else begin
            tap <= tap + TAP_W'(1);
          end
        end
        S_DRAIN1: state <= S_DRAIN2;
        S_DRAIN2: state <= S_FINISH;
        S_FINISH: begin
          if (status.out_free) begin
            residue <= residue_next;
            phase   <= (phase_inc >= (PHASE_W+1)'(l_eff)) ? '0 : phase_inc[PHASE_W-1:0];
            count   <= count + COUNT_W'(1);
            state   <= S_CHECK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
